// ===== sv/gww_pkg.sv =====
// Shared types, constants and helpers for the greedy word wrap block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package gww_pkg;

    // Largest chunk limit the window is sized for, by default.
    localparam int LIMIT_MAX_DEF = 32;

    localparam int CHAR_W  = 8;
    localparam int ENTRY_W = CHAR_W + 1;
    localparam int CFG_W   = 6;

    localparam logic [CHAR_W-1:0] SPACE_CHAR        = 8'h20;
    localparam logic [CFG_W-1:0]  CHUNK_LIMIT_RESET = 6'd3;

    // One buffered position: bit 8 marks the line end, bits 7:0 hold the byte.
    typedef logic [ENTRY_W-1:0] entry_t;

    localparam entry_t END_ENTRY = {1'b1, {CHAR_W{1'b0}}};

    // Control for the whole row of window cells in one cycle.
    typedef struct packed {
        logic load;   // write the new position into the cell at the fill index
        logic shift;  // every cell takes its upper neighbor's entry
    } win_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_EMIT,
        ST_DROP,
        ST_FLUSH
    } state_t;

    function automatic logic is_space(input entry_t e);
        return e == {1'b0, SPACE_CHAR};
    endfunction

endpackage

`default_nettype wire

// ===== sv/greedy_word_wrap.sv =====
// Greedy word wrap with hard break: top level, control and output register.
// Depends on gww_pkg and gww_window (which instantiates gww_cell).
//
//   channel   direction  signals                       payload
//   s_        in         s_tvalid s_tready s_tdata     tdata: in_char; tuser: line_end
//                        s_tuser
//   m_        out        m_tvalid m_tready m_tdata     tdata: out_char; tuser: has_char;
//                        m_tuser m_tlast               tlast: chunk_end
//   cfg_      in         cfg_valid cfg_ready cfg_data  chunk_limit
//
// An input transaction that causes no break is accepted in ST_IDLE, then checked in ST_CHECK.
// Each emitted position passes through the output register, and each space dropped
// after a break is shifted out in ST_DROP. When the limit was lowered mid-line, a break
// may first scan the window one cell a cycle, down from the top cell.
// Reset empties the window and the output register; the window contents need no clearing.
// Back-pressure on m_ holds the emitter in place; s_tready is high only between items.
`default_nettype none

module greedy_word_wrap
    import gww_pkg::*;
#(
    parameter int LIMIT_MAX = LIMIT_MAX_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [CHAR_W-1:0] s_tdata,   // [7:0] in_char
    input  wire logic [0:0]        s_tuser,   // [0] line_end

    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [CHAR_W-1:0]      m_tdata,   // [7:0] out_char
    output logic [0:0]             m_tuser,   // [0] has_char
    output logic                   m_tlast,

    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    localparam int DEPTH = LIMIT_MAX + 1;
    localparam int CW    = $clog2(DEPTH + 1);

    state_t            state_reg, state_next;
    logic [CW-1:0]     fill_reg, fill_next;
    logic [CW-1:0]     lsp_reg, lsp_next;     // last space at offsets 1..fill-1, 0 if none
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic [DEPTH-1:0]  scan_reg, scan_next;
    logic              skip_reg, skip_next;
    logic              le_pend_reg, le_pend_next;
    logic [CFG_W-1:0]  limit_reg, limit_next;

    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_has_reg, out_has_next;
    logic              out_last_reg, out_last_next;

    win_ctrl_t         ctrl;
    entry_t            front;
    entry_t            new_entry;
    logic [DEPTH-1:0]  space_flags;
    logic [CW-1:0]     lim;
    logic              in_fire;
    logic              can_emit;
    logic              in_le;

    gww_window #(
        .DEPTH (DEPTH)
    ) u_window (
        .clk         (clk),
        .ctrl        (ctrl),
        .load_idx    (fill_reg),
        .load_data   (new_entry),
        .front       (front),
        .space_flags (space_flags)
    );

    // Effective limit: zero acts as one, anything above LIMIT_MAX as LIMIT_MAX.
    always_comb
    begin
        if (limit_reg == '0)
        begin
            lim = CW'(1);
        end
        else if (limit_reg > CFG_W'(LIMIT_MAX))
        begin
            lim = CW'(LIMIT_MAX);
        end
        else
        begin
            lim = CW'(limit_reg);
        end
    end

    assign in_le     = s_tuser[0];
    assign new_entry = in_le ? END_ENTRY : {1'b0, s_tdata};
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign can_emit  = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        lsp_next       = lsp_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        scan_next      = scan_reg;
        skip_next      = skip_reg;
        le_pend_next   = le_pend_reg;
        limit_next     = limit_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_has_next   = out_has_reg;
        out_last_next  = out_last_reg;
        ctrl           = '0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            limit_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    // Spaces right after a break that emptied the window are dropped.
                    if (!(skip_reg && !in_le && s_tdata == SPACE_CHAR))
                    begin
                        skip_next    = 1'b0;
                        le_pend_next = in_le;
                        ctrl.load    = 1'b1;
                        fill_next    = fill_reg + CW'(1);
                        if (is_space(new_entry) && fill_reg != '0)
                        begin
                            lsp_next = fill_reg;
                        end
                        state_next = ST_CHECK;
                    end
                end
            end

            ST_CHECK:
            begin
                if (fill_reg > lim)
                begin
                    if (lsp_reg == '0)
                    begin
                        cnt_next   = lim;
                        state_next = ST_EMIT;
                    end
                    else if (lsp_reg <= lim)
                    begin
                        cnt_next   = lsp_reg;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        // The last space lies beyond the limit: look for one below it.
                        for (int j = 0; j < DEPTH; j++)
                        begin
                            scan_next[j] = space_flags[j] && (j != 0) && (CW'(j) <= lim);
                        end
                        pos_next   = CW'(DEPTH - 1);
                        state_next = ST_SCAN;
                    end
                end
                else if (le_pend_reg)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                if (scan_reg[DEPTH-1])
                begin
                    cnt_next   = pos_reg;
                    state_next = ST_EMIT;
                end
                else if (pos_reg == CW'(1))
                begin
                    cnt_next   = lim;
                    state_next = ST_EMIT;
                end
                else
                begin
                    scan_next = {scan_reg[DEPTH-2:0], 1'b0};
                    pos_next  = pos_reg - CW'(1);
                end
            end

            ST_EMIT, ST_FLUSH:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = front[ENTRY_W-1] ? '0 : front[CHAR_W-1:0];
                    out_has_next   = !front[ENTRY_W-1];
                    ctrl.shift     = 1'b1;
                    fill_next      = fill_reg - CW'(1);
                    lsp_next       = (lsp_reg == '0) ? '0 : lsp_reg - CW'(1);
                    if (state_reg == ST_EMIT)
                    begin
                        out_last_next = (cnt_reg == CW'(1));
                        cnt_next      = cnt_reg - CW'(1);
                        if (cnt_reg == CW'(1))
                        begin
                            state_next = ST_DROP;
                        end
                    end
                    else
                    begin
                        out_last_next = (fill_reg == CW'(1));
                        if (fill_reg == CW'(1))
                        begin
                            le_pend_next = 1'b0;
                            skip_next    = 1'b0;
                            state_next   = ST_IDLE;
                        end
                    end
                end
            end

            ST_DROP:
            begin
                if (fill_reg != '0 && space_flags[0])
                begin
                    ctrl.shift = 1'b1;
                    fill_next  = fill_reg - CW'(1);
                    lsp_next   = (lsp_reg == '0) ? '0 : lsp_reg - CW'(1);
                end
                else
                begin
                    skip_next  = (fill_reg == '0);
                    state_next = ST_CHECK;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            lsp_reg       <= '0;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            skip_reg      <= 1'b0;
            le_pend_reg   <= 1'b0;
            limit_reg     <= CHUNK_LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            lsp_reg       <= lsp_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            skip_reg      <= skip_next;
            le_pend_reg   <= le_pend_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg     <= scan_next;
        out_char_reg <= out_char_next;
        out_has_reg  <= out_has_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_char_reg;
    assign m_tuser[0] = out_has_reg;
    assign m_tlast    = out_last_reg;

endmodule

`default_nettype wire

// ===== sv/gww_cell.sv =====
// One cell of the window shift line: holds one buffered position.
// Depends on gww_pkg for the entry type and the control struct.
`default_nettype none

module gww_cell
    import gww_pkg::*;
(
    input  wire logic      clk,
    input  wire win_ctrl_t ctrl,
    input  wire logic      sel,
    input  wire entry_t    load_data,
    input  wire entry_t    upper_data,
    output entry_t         data,
    output logic           space
);

    entry_t data_reg;
    entry_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load && sel)
        begin
            data_next = load_data;
        end
        else if (ctrl.shift)
        begin
            data_next = upper_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign space = is_space(data_reg);

endmodule

`default_nettype wire

// ===== sv/gww_window.sv =====
// Row of window cells; entries move one cell toward the front on a shift.
// Depends on gww_pkg and gww_cell.
`default_nettype none

module gww_window
    import gww_pkg::*;
#(
    parameter int DEPTH = LIMIT_MAX_DEF + 1,
    localparam int IDX_W = $clog2(DEPTH + 1)
)
(
    input  wire logic             clk,
    input  wire win_ctrl_t        ctrl,
    input  wire logic [IDX_W-1:0] load_idx,
    input  wire entry_t           load_data,
    output entry_t                front,
    output logic [DEPTH-1:0]      space_flags
);

    entry_t cell_data [DEPTH];

    for (genvar j = 0; j < DEPTH; j++)
    begin : g_cell
        entry_t upper;

        if (j == DEPTH - 1)
        begin : g_top
            assign upper = '0;
        end
        else
        begin : g_mid
            assign upper = cell_data[j+1];
        end

        gww_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .sel        (load_idx == IDX_W'(j)),
            .load_data  (load_data),
            .upper_data (upper),
            .data       (cell_data[j]),
            .space      (space_flags[j])
        );
    end

    assign front = cell_data[0];

endmodule

`default_nettype wire

// ===== test/greedy_word_wrap_tb.sv =====
// Self-checking testbench for greedy_word_wrap: drives text streams and limit writes,
// predicts every chunk position in a scoreboard class and compares the output stream.
// Depends on gww_pkg and the greedy_word_wrap RTL.
`default_nettype none

module greedy_word_wrap_tb
    import gww_pkg::*;
();

    localparam int     LIMIT_MAX   = LIMIT_MAX_DEF;
    localparam int     STALL_LIMIT = 4000;
    localparam int     SETTLE_CYC  = 100;
    localparam int     NUM_PHASES  = 10;
    localparam int     PHASE_ITEMS = 34;
    localparam entry_t SPACE_ENTRY = {1'b0, SPACE_CHAR};

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              has;
        logic              last;
    } chunk_pos_t;

    // Tracks the line buffer of the block and holds the chunk positions still to come.
    class wrap_scoreboard;
        entry_t           line_buf [LIMIT_MAX+1];
        int               held;
        bit               dropping;
        logic [CFG_W-1:0] limit_reg;
        chunk_pos_t       pending_pos [$];
        int               errors;

        function new();
            held      = 0;
            dropping  = 0;
            limit_reg = CHUNK_LIMIT_RESET;
            errors    = 0;
        endfunction

        function int eff_limit();
            if (limit_reg == 0)
                return 1;
            if (limit_reg > LIMIT_MAX)
                return LIMIT_MAX;
            return limit_reg;
        endfunction

        function void set_limit(logic [CFG_W-1:0] v);
            limit_reg = v;
        endfunction

        function int pending();
            return pending_pos.size();
        endfunction

        function void push(entry_t e, bit last);
            chunk_pos_t p;
            p.ch   = e[CHAR_W] ? '0 : e[CHAR_W-1:0];
            p.has  = !e[CHAR_W];
            p.last = last;
            pending_pos.push_back(p);
        endfunction

        function void shift_out(int k);
            int i;
            if (k >= held)
            begin
                held = 0;
                return;
            end
            for (i = 0; i < held - k; i++)
                line_buf[i] = line_buf[i+k];
            held -= k;
        endfunction

        // Break before the last space at offsets 1..lim, or hard-break at lim.
        function void cut_chunk(int lim);
            int cut;
            int i;
            cut = lim;
            for (i = lim; i >= 1; i--)
            begin
                if (line_buf[i] == SPACE_ENTRY)
                begin
                    cut = i;
                    break;
                end
            end
            for (i = 0; i < cut; i++)
                push(line_buf[i], i + 1 == cut);
            shift_out(cut);
            while (held > 0 && line_buf[0] == SPACE_ENTRY)
                shift_out(1);
            dropping = (held == 0);
        endfunction

        function void note_input(logic [CHAR_W-1:0] ch, logic le);
            int lim;
            int i;
            lim = eff_limit();
            if (!le && dropping && ch == SPACE_CHAR)
                return;
            dropping = 0;
            if (held > LIMIT_MAX)
                held = LIMIT_MAX;
            line_buf[held] = le ? END_ENTRY : {1'b0, ch};
            held++;
            while (held > lim)
                cut_chunk(lim);
            if (le && held > 0)
            begin
                for (i = 0; i < held; i++)
                    push(line_buf[i], i + 1 == held);
                held     = 0;
                dropping = 0;
            end
        endfunction

        function void check_result(logic [CHAR_W-1:0] ch, logic has, logic last);
            chunk_pos_t p;
            if (pending_pos.size() == 0)
            begin
                $display("%0t: unexpected result char=%h has_char=%b chunk_end=%b",
                         $time, ch, has, last);
                errors++;
                return;
            end
            p = pending_pos.pop_front();
            if (ch !== p.ch)
            begin
                $display("%0t: out_char expected %h actual %h", $time, p.ch, ch);
                errors++;
            end
            if (has !== p.has)
            begin
                $display("%0t: has_char expected %b actual %b", $time, p.has, has);
                errors++;
            end
            if (last !== p.last)
            begin
                $display("%0t: chunk_end expected %b actual %b", $time, p.last, last);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [CHAR_W-1:0] s_tdata;
    logic [0:0]        s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [CHAR_W-1:0] m_tdata;
    logic [0:0]        m_tuser;
    logic              m_tlast;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data;

    wrap_scoreboard sb;
    bit             no_idle;
    int             quiet_cycles;

    greedy_word_wrap #(
        .LIMIT_MAX (LIMIT_MAX)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [7:0] in_char
        .s_tuser   (s_tuser),     // [0] line_end
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // [7:0] out_char
        .m_tuser   (m_tuser),     // [0] has_char
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // The receiver stalls at random except while the no-idle stretch runs.
    always @(negedge clk)
    begin
        m_tready <= no_idle || ($urandom_range(99) >= 6);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser[0], m_tlast);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("greedy_word_wrap regression: fail");
                $finish;
            end
        end
    end

    function automatic logic [CHAR_W-1:0] text_byte();
        logic [CHAR_W-1:0] c;
        c = CHAR_W'($urandom_range(0, 255));
        if (c == SPACE_CHAR)
            c = 8'h21;
        return c;
    endfunction

    task automatic send_item(logic [CHAR_W-1:0] ch, logic le);
        if (!no_idle && $urandom_range(99) < 6)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = ch;
        s_tuser  = le;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(ch, le);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic send_text(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    // Waits until every predicted position has come out, then lets the block settle.
    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_limit(logic [CFG_W-1:0] v);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_data  = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_limit(v);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Mostly words and spaces with line ends, plus some raw bytes and stray line ends.
    task automatic send_random_text(int n);
        int count;
        int r;
        int len;
        int nsp;
        int lim;
        int j;
        count = 0;
        while (count < n)
        begin
            lim = sb.eff_limit();
            r   = $urandom_range(99);
            if (r < 8)
            begin
                send_item(CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                count++;
            end
            else if (r < 22)
            begin
                send_item(CHAR_W'($urandom_range(0, 255)), 1'b1);
                count++;
            end
            else
            begin
                if ($urandom_range(7) == 0)
                    len = lim + $urandom_range(1, 6);
                else
                    len = $urandom_range(1, lim);
                for (j = 0; j < len; j++)
                    send_item(text_byte(), 1'b0);
                if ($urandom_range(9) == 0)
                    nsp = $urandom_range(1, lim + 2);
                else
                    nsp = $urandom_range(1, 2);
                for (j = 0; j < nsp; j++)
                    send_item(SPACE_CHAR, 1'b0);
                count += len + nsp;
            end
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] plan [NUM_PHASES];
        int               p;
        int               tail;
        int               j;

        sb        = new();
        no_idle   = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        quiet_cycles = 0;

        plan[0] = 6'd1;
        plan[1] = 6'd32;
        plan[2] = 6'd2;
        plan[3] = 6'd0;
        plan[4] = 6'd63;
        plan[5] = 6'd33;
        plan[6] = 6'd7;
        for (p = 7; p < NUM_PHASES; p++)
            plan[p] = CFG_W'($urandom_range(0, 63));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part at the reset limit: break at a space with spaces dropped after it,
        // a hard break, zero and all-ones bytes, leading spaces and an empty line.
        send_text("ab cd  e");
        send_item(SPACE_CHAR, 1'b1);
        send_text("wxyz");
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b1);
        send_text("  q");
        send_item(8'h00, 1'b1);
        send_item(8'h00, 1'b1);

        // The sender holds off until the block has delivered everything.
        wait_drained();

        for (p = 0; p < NUM_PHASES; p++)
        begin
            write_limit(plan[p]);
            no_idle = (p == 4 || p == 5);
            send_random_text(PHASE_ITEMS);
            // End the phase mid-line so the next write can lower the limit on a full buffer.
            tail = (p == 1) ? sb.eff_limit() : $urandom_range(0, sb.eff_limit());
            for (j = 0; j < tail; j++)
                send_item(text_byte(), 1'b0);
        end
        no_idle = 1'b0;
        send_item(8'h00, 1'b1);

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("greedy_word_wrap regression: pass");
        else
            $display("greedy_word_wrap regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
